>>> src/assert_macros.svh
// Assertion macros used by the RTL of the top-k insertion sorter.
// Stand-alone header; the top level, which checks its own logic, includes it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("%m: invariant violated");
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication violated");
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication violated");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> src/tks_pkg.sv
// Shared constants and types of the top-k insertion sorter.
// No dependencies; tks_cell, tks_chain and the top level import it.
package tks_pkg;

  // Width of the configuration data word that sets the keep count.
  localparam int CFG_W = 5;
  // Keep count after reset, before clamping to the chain length.
  localparam int KEEP_RESET = 16;

  // Operation codes of an input word.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // Command from the sequencer to the cell chain.
  typedef struct packed {
    logic insert;  // place the broadcast item and shift the tail down
    logic rotate;  // move every kept entry one place toward the head
  } chain_ctl_t;

endpackage

>>> src/tks_ifs.sv
// Valid/ready channel interfaces of the top-k insertion sorter.
// No dependencies; used by the top level.
interface tks_item_if #(
  parameter int SCORE_BITS = 16,
  parameter int TAG_BITS   = 16
);
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [SCORE_BITS-1:0] score;
  logic [TAG_BITS-1:0]   tag;

  modport source (output valid, op, score, tag, input ready);
  modport sink   (input valid, op, score, tag, output ready);
endinterface

interface tks_result_if #(
  parameter int POS_W      = 5,
  parameter int SCORE_BITS = 16,
  parameter int TAG_BITS   = 16
);
  logic                  valid;
  logic                  ready;
  logic [POS_W-1:0]      position;
  logic [SCORE_BITS-1:0] entry_score;
  logic [TAG_BITS-1:0]   entry_tag;
  logic                  entry_valid;
  logic                  last;

  modport source (output valid, position, entry_score, entry_tag, entry_valid, last,
                  input ready);
  modport sink   (input valid, position, entry_score, entry_tag, entry_valid, last,
                  output ready);
endinterface

>>> src/tks_cell.sv
// One entry of the sorted list: score and tag registers plus compare logic.
// Depends on tks_pkg for the chain command type.
module tks_cell #(
  parameter int SCORE_BITS = 16,
  parameter int TAG_BITS   = 16
) (
  input  logic                  clk,
  input  tks_pkg::chain_ctl_t   ctl,
  input  logic                  occ,
  input  logic [SCORE_BITS-1:0] new_score,
  input  logic [TAG_BITS-1:0]   new_tag,
  input  logic                  prev_ge,
  input  logic [SCORE_BITS-1:0] prev_score,
  input  logic [TAG_BITS-1:0]   prev_tag,
  input  logic [SCORE_BITS-1:0] next_score,
  input  logic [TAG_BITS-1:0]   next_tag,
  output logic [SCORE_BITS-1:0] score,
  output logic [TAG_BITS-1:0]   tag,
  output logic                  ge
);
  import tks_pkg::*;

  // An occupied entry at or above the new score stays where it is.
  assign ge = occ && (score >= new_score);

  always_ff @(posedge clk) begin
    if (ctl.insert) begin
      if (!ge) begin
        if (prev_ge) begin
          score <= new_score;
          tag   <= new_tag;
        end else begin
          score <= prev_score;
          tag   <= prev_tag;
        end
      end
    end else if (ctl.rotate) begin
      score <= next_score;
      tag   <= next_tag;
    end
  end

endmodule

>>> src/tks_chain.sv
// Row of list cells with neighbor links and the insert position encoder.
// Depends on tks_pkg and tks_cell.
module tks_chain #(
  parameter int MAX_KEEP   = 16,
  parameter int SCORE_BITS = 16,
  parameter int TAG_BITS   = 16,
  parameter int POS_W      = 5
) (
  input  logic                  clk,
  input  tks_pkg::chain_ctl_t   ctl,
  input  logic [POS_W-1:0]      fill,
  input  logic [SCORE_BITS-1:0] new_score,
  input  logic [TAG_BITS-1:0]   new_tag,
  output logic [POS_W-1:0]      pos,
  output logic [SCORE_BITS-1:0] head_score,
  output logic [TAG_BITS-1:0]   head_tag
);
  import tks_pkg::*;

  logic [SCORE_BITS-1:0] cell_score [MAX_KEEP];
  logic [TAG_BITS-1:0]   cell_tag   [MAX_KEEP];
  logic [MAX_KEEP-1:0]   ge;
  logic [MAX_KEEP:0]     ge_ext;
  logic [MAX_KEEP:0]     prev_ge;

  assign ge_ext  = {1'b0, ge};
  assign prev_ge = {ge, 1'b1};

  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    logic                  occ;
    logic [SCORE_BITS-1:0] prev_score;
    logic [TAG_BITS-1:0]   prev_tag;
    logic [SCORE_BITS-1:0] next_score;
    logic [TAG_BITS-1:0]   next_tag;

    assign occ = POS_W'(i) < fill;

    if (i == 0) begin : g_head
      assign prev_score = new_score;
      assign prev_tag   = new_tag;
    end else begin : g_body
      assign prev_score = cell_score[i-1];
      assign prev_tag   = cell_tag[i-1];
    end

    // During read-out the occupied part of the row turns as a ring.
    if (i == MAX_KEEP - 1) begin : g_tail
      assign next_score = cell_score[0];
      assign next_tag   = cell_tag[0];
    end else begin : g_link
      logic wrap;
      assign wrap       = !(POS_W'(i + 1) < fill);
      assign next_score = wrap ? cell_score[0] : cell_score[i+1];
      assign next_tag   = wrap ? cell_tag[0] : cell_tag[i+1];
    end

    tks_cell #(
      .SCORE_BITS(SCORE_BITS),
      .TAG_BITS  (TAG_BITS)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (occ),
      .new_score (new_score),
      .new_tag   (new_tag),
      .prev_ge   (prev_ge[i]),
      .prev_score(prev_score),
      .prev_tag  (prev_tag),
      .next_score(next_score),
      .next_tag  (next_tag),
      .score     (cell_score[i]),
      .tag       (cell_tag[i]),
      .ge        (ge[i])
    );
  end

  // The compare results form a run of ones from the head; the insert
  // position is where that run ends.
  always_comb begin
    pos = '0;
    for (int i = 0; i <= MAX_KEEP; i++) begin
      if (prev_ge[i] && !ge_ext[i]) begin
        pos = pos | POS_W'(i);
      end
    end
  end

  assign head_score = cell_score[0];
  assign head_tag   = cell_tag[0];

endmodule

>>> src/top_k_sorted_insert.sv
// Top level of the top-k insertion sorter: sequencer, fill and keep
// registers, output register. Depends on tks_pkg, tks_ifs, tks_chain.
//
// Usage: words arrive on the items channel (op, score, tag) and results
// leave on the results channel (position, entry_score, entry_tag,
// entry_valid, last); both use valid/ready. An insert word is compared
// against every kept entry at once in the cell chain and produces exactly
// one result word; inserts are taken one per cycle while no read-out is in
// progress, and the result appears in the output register on the cycle
// after acceptance. A read-out word produces one result per kept entry,
// highest score first, the last one marked; the chain turns as a ring by
// one place per delivered word, no item is taken until the last word is loaded,
// and the list ends unchanged. An empty list answers a read-out with one
// word marked empty. While the receiver holds ready low the output register
// keeps its word, no new item is taken, and a read-out in progress pauses.
// Reset empties the list and sets the keep count to its default; the entry
// registers themselves are not cleared. The keep count is written through
// cfg_we/cfg_data while the block is idle; 0 acts as 1, values above
// MAX_KEEP act as MAX_KEEP, and lowering it drops entries beyond the new count.
`include "assert_macros.svh"

module top_k_sorted_insert #(
  parameter int MAX_KEEP   = 16,
  parameter int SCORE_BITS = 16,
  parameter int TAG_BITS   = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  tks_item_if.sink                  items,
  tks_result_if.source              results,
  input  logic                      cfg_we,
  input  logic [tks_pkg::CFG_W-1:0] cfg_data
);
  import tks_pkg::*;

  localparam int POS_W = $clog2(MAX_KEEP + 1);
  localparam int CMP_W = (POS_W > CFG_W) ? POS_W : CFG_W;
  localparam int RESET_KEEP = (KEEP_RESET > MAX_KEEP) ? MAX_KEEP : KEEP_RESET;

  // Control state.
  logic [POS_W-1:0] fill, fill_next;
  logic [POS_W-1:0] keep, keep_next;
  logic             reading, reading_next;
  logic [POS_W-1:0] rd_idx, rd_idx_next;
  logic             out_valid, out_valid_next;

  // Output payload register.
  logic [POS_W-1:0]      out_pos, res_pos;
  logic [SCORE_BITS-1:0] out_score, res_score;
  logic [TAG_BITS-1:0]   out_tag, res_tag;
  logic                  out_evalid, res_evalid;
  logic                  out_last, res_last;
  logic                  load;

  logic                  load_ok;
  logic                  accept;
  logic [CMP_W-1:0]      cfg_wide;
  logic [POS_W-1:0]      cfg_keep;
  chain_ctl_t            ctl;
  logic [POS_W-1:0]      ins_pos;
  logic [SCORE_BITS-1:0] head_score;
  logic [TAG_BITS-1:0]   head_tag;

  // The output register can take a new word when it is empty or being drained.
  assign load_ok     = !out_valid || results.ready;
  assign items.ready = !reading && load_ok;
  assign accept      = items.valid && items.ready;

  tks_chain #(
    .MAX_KEEP  (MAX_KEEP),
    .SCORE_BITS(SCORE_BITS),
    .TAG_BITS  (TAG_BITS),
    .POS_W     (POS_W)
  ) u_chain (
    .clk       (clk),
    .ctl       (ctl),
    .fill      (fill),
    .new_score (items.score),
    .new_tag   (items.tag),
    .pos       (ins_pos),
    .head_score(head_score),
    .head_tag  (head_tag)
  );

  // Clamp the written keep count into 1..MAX_KEEP.
  assign cfg_wide = CMP_W'(cfg_data);
  always_comb begin
    if (cfg_wide == '0) begin
      cfg_keep = POS_W'(1);
    end else if (cfg_wide > CMP_W'(MAX_KEEP)) begin
      cfg_keep = POS_W'(MAX_KEEP);
    end else begin
      cfg_keep = POS_W'(cfg_wide);
    end
  end

  // Sequencer: one result per insert, a train of results per read-out.
  always_comb begin
    ctl          = '0;
    load         = 1'b0;
    res_pos      = '0;
    res_score    = '0;
    res_tag      = '0;
    res_evalid   = 1'b0;
    res_last     = 1'b1;
    fill_next    = fill;
    keep_next    = keep;
    reading_next = reading;
    rd_idx_next  = rd_idx;

    if (accept && (items.op == OP_INSERT)) begin
      load      = 1'b1;
      res_score = items.score;
      res_tag   = items.tag;
      if (ins_pos < keep) begin
        // The item lands inside the kept range; the tail shifts down.
        ctl.insert = 1'b1;
        res_pos    = ins_pos;
        res_evalid = 1'b1;
        if (fill < keep) begin
          fill_next = fill + POS_W'(1);
        end
      end else begin
        res_pos = keep;
      end
    end else if (accept && (items.op == OP_READ)) begin
      load = 1'b1;
      if (fill != '0) begin
        ctl.rotate = 1'b1;
        res_score  = head_score;
        res_tag    = head_tag;
        res_evalid = 1'b1;
        res_last   = (fill == POS_W'(1));
        if (fill != POS_W'(1)) begin
          reading_next = 1'b1;
          rd_idx_next  = POS_W'(1);
        end
      end
    end else if (reading && load_ok) begin
      load       = 1'b1;
      ctl.rotate = 1'b1;
      res_pos    = rd_idx;
      res_score  = head_score;
      res_tag    = head_tag;
      res_evalid = 1'b1;
      res_last   = ((rd_idx + POS_W'(1)) == fill);
      rd_idx_next = rd_idx + POS_W'(1);
      if (res_last) begin
        reading_next = 1'b0;
      end
    end

    // Configuration writes must arrive only while the block is idle; unchecked.
    if (cfg_we) begin
      keep_next = cfg_keep;
      if (fill > cfg_keep) begin
        fill_next = cfg_keep;
      end
    end

    if (load) begin
      out_valid_next = 1'b1;
    end else if (results.ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      keep      <= POS_W'(RESET_KEEP);
      reading   <= 1'b0;
      rd_idx    <= '0;
      out_valid <= 1'b0;
    end else begin
      fill      <= fill_next;
      keep      <= keep_next;
      reading   <= reading_next;
      rd_idx    <= rd_idx_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_pos    <= res_pos;
      out_score  <= res_score;
      out_tag    <= res_tag;
      out_evalid <= res_evalid;
      out_last   <= res_last;
    end
  end

  assign results.valid       = out_valid;
  assign results.position    = out_pos;
  assign results.entry_score = out_score;
  assign results.entry_tag   = out_tag;
  assign results.entry_valid = out_evalid;
  assign results.last        = out_last;

  // The list never holds more entries than the keep count allows.
  `ASSERT_ALWAYS(a_fill_in_range, clk, rst, (fill <= keep) && (keep != '0))
  // A read-out in progress always points at a kept entry past the head.
  `ASSERT_IMPLIES(a_read_index, clk, rst, reading, (rd_idx != '0) && (rd_idx < fill))
  // A read-out of more than one entry keeps the block busy afterward.
  `ASSERT_NEXT(a_read_start, clk, rst,
               accept && (items.op == OP_READ) && (fill > POS_W'(1)), reading)
  // Absent a config write, a kept insert into a non-full list adds exactly one.
  `ASSERT_NEXT(a_fill_grows, clk, rst,
               ctl.insert && (fill < keep) && !cfg_we, fill == ($past(fill) + POS_W'(1)))

endmodule
